// File: rtl/core/unique_edge_table_builder_core_macros.svh
// Assertion helpers shared by the edge table builder modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef UNIQUE_EDGE_TABLE_BUILDER_CORE_MACROS_SVH
`define UNIQUE_EDGE_TABLE_BUILDER_CORE_MACROS_SVH

`define UETB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define UETB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/uetb_pkg.sv
package uetb_pkg;

  localparam int VTX_W  = 16;
  localparam int SLOT_W = 10;

  typedef struct packed {
    logic [VTX_W-1:0] vertex_index;
    logic             face_end;
    logic             mesh_start;
  } in_word_t;

  typedef struct packed {
    logic [VTX_W-1:0]  edge_start_vertex;
    logic [VTX_W-1:0]  edge_end_vertex;
    logic [SLOT_W-1:0] edge_slot;
    logic              table_overflow;
    logic              run_last;
  } out_word_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_rsp_t;

endpackage

// File: rtl/core/uetb_ram.sv
module uetb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/uetb_search.sv
`include "unique_edge_table_builder_core_macros.svh"

module uetb_search #(
  parameter int VB    = 16,
  parameter int SLOTS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [VB-1:0]              edge_a,
  input  logic [VB-1:0]              edge_b,
  input  logic [$clog2(SLOTS+1)-1:0] total,
  output logic                       rd_en,
  output logic [$clog2(SLOTS)-1:0]   rd_addr,
  input  logic [2*VB-1:0]            rd_data,
  output uetb_pkg::srch_rsp_t        rsp
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS+1);

  logic          busy_r, busy_nxt;
  logic          chk_r, chk_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [VB-1:0] rd_a, rd_b;
  logic          more, match, hit_now;

  assign rd_a    = rd_data[2*VB-1:VB];
  assign rd_b    = rd_data[VB-1:0];
  assign match   = (rd_a == edge_a && rd_b == edge_b) || (rd_a == edge_b && rd_b == edge_a);
  assign more    = idx_r < total;
  assign hit_now = chk_r && match;
  assign rd_en   = busy_r && more && !hit_now;
  assign rd_addr = idx_r[AW-1:0];

  assign rsp.done = busy_r && (hit_now || (!chk_r && !more));
  assign rsp.hit  = hit_now;

  always_comb begin
    busy_nxt = busy_r;
    chk_nxt  = chk_r;
    idx_nxt  = idx_r;
    if (go) begin
      busy_nxt = 1'b1;
      chk_nxt  = 1'b0;
      idx_nxt  = '0;
    end else if (rsp.done) begin
      busy_nxt = 1'b0;
      chk_nxt  = 1'b0;
    end else if (busy_r) begin
      chk_nxt = rd_en;
      if (rd_en) begin
        idx_nxt = idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      chk_r  <= chk_nxt;
      idx_r  <= idx_nxt;
    end
  end

  `UETB_ASSERT_IMP(a_go_when_free, go, !busy_r, "Search started while one is running.")
  `UETB_ASSERT_NXT(a_done_frees, rsp.done && !go, !busy_r, "Search still busy after done.")
  `UETB_ASSERT_IMP(a_idx_bound, busy_r, idx_r <= total, "Scan index beyond stored edges.")

endmodule

// File: rtl/core/unique_edge_table_builder_core.sv
// A word that opens a face runs no scan. A word that closes or extends a face runs
// one or two scans of the edge memory, then hands out its results, waiting while
// the result side stalls. One slot is read per cycle from the single read port of
// the edge memory. Reset empties the table and closes any face at once; memory
// contents are left, as only slots below the count are read.
`include "unique_edge_table_builder_core_macros.svh"

module unique_edge_table_builder_core #(
  parameter int EDGE_SLOTS  = 1024,
  parameter int VERTEX_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  uetb_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output uetb_pkg::out_word_t  out_data
);

  localparam int VW = uetb_pkg::VTX_W;
  localparam int SW = uetb_pkg::SLOT_W;
  localparam int VB = (VERTEX_BITS < VW) ? VERTEX_BITS : VW;
  localparam int AW = $clog2(EDGE_SLOTS);
  localparam int CW = $clog2(EDGE_SLOTS+1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       total_r, total_nxt;
  logic [VB-1:0]       first_r, first_nxt;
  logic [VB-1:0]       prev_r, prev_nxt;
  logic                open_r, open_nxt;
  logic [VB-1:0]       ea_r, ea_nxt;
  logic [VB-1:0]       eb_r, eb_nxt;
  logic                second_r, second_nxt;
  logic                sel_r, sel_nxt;
  logic                go_r, go_nxt;
  uetb_pkg::out_word_t res0_r, res0_nxt;
  uetb_pkg::out_word_t res1_r, res1_nxt;
  logic                res0_v_r, res0_v_nxt;
  logic                res1_v_r, res1_v_nxt;
  logic                out_valid_r, out_valid_nxt;
  uetb_pkg::out_word_t out_data_r, out_data_nxt;

  uetb_pkg::out_word_t rec;
  uetb_pkg::srch_rsp_t rsp;
  logic [VB-1:0]       v;
  logic                accept, open_eff, load;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [2*VB-1:0]     ram_rdata;

  assign v        = in_data.vertex_index[VB-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign open_eff = open_r && !in_data.mesh_start;

  always_comb begin
    rec.edge_start_vertex = VW'(ea_r);
    rec.edge_end_vertex   = VW'(eb_r);
    rec.run_last          = 1'b0;
    if (total_r >= CW'(EDGE_SLOTS)) begin
      rec.table_overflow = 1'b1;
      rec.edge_slot      = '0;
    end else begin
      rec.table_overflow = 1'b0;
      rec.edge_slot      = SW'(total_r);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    first_nxt    = first_r;
    prev_nxt     = prev_r;
    open_nxt     = open_r;
    ea_nxt       = ea_r;
    eb_nxt       = eb_r;
    second_nxt   = second_r;
    sel_nxt      = sel_r;
    go_nxt       = 1'b0;
    res0_nxt     = res0_r;
    res1_nxt     = res1_r;
    res0_v_nxt   = res0_v_r;
    res1_v_nxt   = res1_v_r;
    out_data_nxt = out_data_r;
    ram_we       = 1'b0;
    load         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.mesh_start) begin
            total_nxt = '0;
          end
          if (!open_eff) begin
            first_nxt = v;
            prev_nxt  = v;
            open_nxt  = !in_data.face_end;
          end else begin
            ea_nxt     = prev_r;
            eb_nxt     = v;
            prev_nxt   = v;
            second_nxt = in_data.face_end;
            open_nxt   = !in_data.face_end;
            sel_nxt    = 1'b0;
            go_nxt     = 1'b1;
            res0_v_nxt = 1'b0;
            res1_v_nxt = 1'b0;
            state_nxt  = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (rsp.done) begin
          if (!rsp.hit) begin
            if (!rec.table_overflow) begin
              ram_we    = 1'b1;
              total_nxt = total_r + CW'(1);
            end
            if (!sel_r) begin
              res0_nxt   = rec;
              res0_v_nxt = 1'b1;
            end else begin
              res1_nxt   = rec;
              res1_v_nxt = 1'b1;
            end
          end
          if (!sel_r && second_r) begin
            sel_nxt = 1'b1;
            ea_nxt  = eb_r;
            eb_nxt  = first_r;
            go_nxt  = 1'b1;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!res0_v_r && !res1_v_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          load = 1'b1;
          if (res0_v_r) begin
            out_data_nxt          = res0_r;
            out_data_nxt.run_last = !res1_v_r;
            res0_v_nxt            = 1'b0;
            if (!res1_v_r) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_data_nxt          = res1_r;
            out_data_nxt.run_last = 1'b1;
            res1_v_nxt            = 1'b0;
            state_nxt             = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      first_r     <= '0;
      prev_r      <= '0;
      open_r      <= 1'b0;
      sel_r       <= 1'b0;
      second_r    <= 1'b0;
      go_r        <= 1'b0;
      res0_v_r    <= 1'b0;
      res1_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      first_r     <= first_nxt;
      prev_r      <= prev_nxt;
      open_r      <= open_nxt;
      sel_r       <= sel_nxt;
      second_r    <= second_nxt;
      go_r        <= go_nxt;
      res0_v_r    <= res0_v_nxt;
      res1_v_r    <= res1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ea_r       <= ea_nxt;
    eb_r       <= eb_nxt;
    res0_r     <= res0_nxt;
    res1_r     <= res1_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  uetb_search #(
    .VB    (VB),
    .SLOTS (EDGE_SLOTS)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go_r),
    .edge_a  (ea_r),
    .edge_b  (eb_r),
    .total   (total_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .rsp     (rsp)
  );

  uetb_ram #(
    .WIDTH (2*VB),
    .DEPTH (EDGE_SLOTS)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total_r[AW-1:0]),
    .wdata ({ea_r, eb_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `UETB_ASSERT_IMP(a_total_bound, 1'b1, total_r <= CW'(EDGE_SLOTS), "Edge count beyond table size.")
  `UETB_ASSERT_IMP(a_write_room, ram_we, total_r < CW'(EDGE_SLOTS), "Edge written into a full table.")
  `UETB_ASSERT_NXT(a_emit_drained, state_r == S_EMIT && state_nxt == S_IDLE, !res0_v_r && !res1_v_r, "Results left behind on return to idle.")

endmodule
